>>> hdl/rfa_pkg.sv
// ---------------------------------------------------------------------------
// rfa_pkg
// Shared types and codes for the reference-counted first-fit allocator.
// ---------------------------------------------------------------------------
package rfa_pkg;

  localparam int DEF_MAX_BLOCKS = 64;
  localparam int DEF_ID_BITS    = 16;

  localparam logic [31:0]        POOL_RESET = 32'd1048576;
  localparam logic signed [15:0] REFS_MAX   = 16'sh7fff;
  localparam logic signed [15:0] REFS_MIN   = 16'sh8000;
  localparam logic [6:0]         FREED_MAX  = 7'd127;

  typedef enum logic [1:0] {
    FN_ALLOC   = 2'd0,
    FN_INC     = 2'd1,
    FN_DEC     = 2'd2,
    FN_COLLECT = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NOFIT   = 2'd1,
    ST_BADID   = 2'd2,
    ST_EXHAUST = 2'd3
  } status_t;

  typedef struct packed {
    func_t       func;
    logic [31:0] request_size;
    logic [15:0] target_id;
  } cmd_t;

  typedef struct packed {
    status_t     status;
    logic [15:0] granted_id;
    logic [6:0]  freed_count;
  } res_t;

endpackage

>>> hdl/refcounted_first_fit_allocator_top.sv
// ---------------------------------------------------------------------------
// refcounted_first_fit_allocator_top
// Pool allocator with reference counts, first-fit by id, and coalescing.
// ---------------------------------------------------------------------------
// Allocate/increment/decrement each run one full scan of the table memory
//   through its single read port.
// Collect runs a freeing scan, then one table scan per ordered step of the
//   merge walk.
// One word is worked on at a time; a finished result waits in the output
//   register while the next word is taken.
// Reset (synchronous, rst high) and each pool_bytes write pass through the
//   init state, which writes entry zero; input is stalled while in it.
// ---------------------------------------------------------------------------
module refcounted_first_fit_allocator_top #(
  parameter int MAX_BLOCKS = rfa_pkg::DEF_MAX_BLOCKS,
  parameter int ID_BITS    = rfa_pkg::DEF_ID_BITS
) (
  input  logic        clk,
  input  logic        rst,
  // request channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  func,
  input  logic [31:0] request_size,
  input  logic [15:0] target_id,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  status,
  output logic [15:0] granted_id,
  output logic [6:0]  freed_count,
  // pool size register
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] pool_bytes
);
  import rfa_pkg::*;

  localparam int AW = $clog2(MAX_BLOCKS);
  localparam int WW = ID_BITS + 80;

  cmd_t          cmd;
  res_t          res;
  res_t          out_q;
  logic          res_valid;
  logic          res_ready;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [WW-1:0] mem_wdata;
  logic [AW-1:0] mem_raddr;
  logic [WW-1:0] mem_rdata;

  assign cmd = '{func: func_t'(func), request_size: request_size, target_id: target_id};

  // Table: {id, offset, length, refs} per entry; valid/free flags live in
  // the sequencer.
  rfa_table_mem #(
    .DEPTH (MAX_BLOCKS),
    .WIDTH (WW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  rfa_ctrl #(
    .MAX_BLOCKS (MAX_BLOCKS),
    .ID_BITS    (ID_BITS)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .cmd_valid (in_valid),
    .cmd_stall (in_stall),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (pool_bytes),
    .res       (res),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  // Output register: frees the sequencer as soon as the result is parked.
  assign res_ready = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      if (res_valid && res_ready) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_q <= res;
    end
  end

  assign status      = out_q.status;
  assign granted_id  = out_q.granted_id;
  assign freed_count = out_q.freed_count;

endmodule

>>> hdl/rfa_table_mem.sv
// ---------------------------------------------------------------------------
// rfa_table_mem
// Block table storage: one write port, one read port, registered read data.
// ---------------------------------------------------------------------------
module rfa_table_mem #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 96,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

>>> hdl/rfa_ctrl.sv
// ---------------------------------------------------------------------------
// rfa_ctrl
// Sequencer: table scans, allocate/split, count update, collect and merge.
// ---------------------------------------------------------------------------
module rfa_ctrl #(
  parameter int MAX_BLOCKS = 64,
  parameter int ID_BITS    = 16,
  localparam int AW        = $clog2(MAX_BLOCKS),
  localparam int WW        = ID_BITS + 80
) (
  input  logic          clk,
  input  logic          rst,
  input  rfa_pkg::cmd_t cmd,
  input  logic          cmd_valid,
  output logic          cmd_stall,
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic [31:0]   cfg_data,
  output rfa_pkg::res_t res,
  output logic          res_valid,
  input  logic          res_ready,
  output logic          mem_we,
  output logic [AW-1:0] mem_waddr,
  output logic [WW-1:0] mem_wdata,
  output logic [AW-1:0] mem_raddr,
  input  logic [WW-1:0] mem_rdata
);
  import rfa_pkg::*;

  localparam int            EW   = (ID_BITS > 16) ? ID_BITS : 16;
  localparam logic [AW-1:0] LAST = AW'(MAX_BLOCKS - 1);

  typedef enum logic [8:0] {
    S_INIT  = 9'b000000001,
    S_IDLE  = 9'b000000010,
    S_SCAN  = 9'b000000100,
    S_EVAL  = 9'b000001000,
    S_WR2   = 9'b000010000,
    S_MSCAN = 9'b000100000,
    S_MEVAL = 9'b001000000,
    S_DONE  = 9'b010000000,
    S_SPARE = 9'b100000000
  } state_t;

  state_t state;
  func_t  op;
  logic [31:0] req_size;
  logic [15:0] req_tid;
  logic [31:0] pool;
  logic [MAX_BLOCKS-1:0] valid_q;
  logic [MAX_BLOCKS-1:0] free_q;
  logic [ID_BITS-1:0] next_ident;

  logic          issuing;
  logic [AW-1:0] issue_cnt;
  logic          rv;
  logic [AW-1:0] ridx;

  // pick / successor candidate
  logic               found;
  logic [AW-1:0]      pk_idx;
  logic [ID_BITS-1:0] pk_ident;
  logic [31:0]        pk_off;
  logic [31:0]        pk_len;
  logic signed [15:0] pk_refs;
  logic               pk_free;
  logic               slot_found;
  logic [AW-1:0]      slot_idx;
  logic [6:0]         freed;

  // merge walk
  logic               have_prev;
  logic [31:0]        prev_off;
  logic [ID_BITS-1:0] prev_ident;
  logic               cur_valid;
  logic               cur_dirty;
  logic               cur_free;
  logic [AW-1:0]      cur_idx;
  logic [ID_BITS-1:0] cur_ident;
  logic [31:0]        cur_off;
  logic [31:0]        cur_len;
  logic signed [15:0] cur_refs;

  res_t res_q;

  // read word fields
  logic [ID_BITS-1:0] r_ident;
  logic [31:0]        r_off;
  logic [31:0]        r_len;
  logic signed [15:0] r_refs;
  logic               r_v;
  logic               r_f;
  logic [EW-1:0]      gext;
  logic [31:0]        rest;
  logic               split_ok;
  logic               merge_ok;
  logic signed [15:0] refs_upd;
  logic               cmd_fire;
  logic               cfg_fire;

  assign r_ident = mem_rdata[WW-1 -: ID_BITS];
  assign r_off   = mem_rdata[79:48];
  assign r_len   = mem_rdata[47:16];
  assign r_refs  = mem_rdata[15:0];
  assign r_v     = valid_q[ridx];
  assign r_f     = free_q[ridx];

  assign cfg_ready = (state == S_IDLE) || (state == S_INIT);
  assign cmd_stall = !((state == S_IDLE) && !cfg_valid);
  assign cmd_fire  = cmd_valid && !cmd_stall;
  assign cfg_fire  = cfg_valid && cfg_ready;
  assign mem_raddr = issue_cnt;
  assign res       = res_q;
  assign res_valid = (state == S_DONE);

  assign rest     = pk_len - req_size;
  assign split_ok = slot_found && (next_ident != '1);
  assign merge_ok = cur_valid && cur_free && pk_free &&
                    (({1'b0, cur_off} + {1'b0, cur_len}) == {1'b0, pk_off});
  assign gext     = EW'(pk_ident);

  always_comb begin
    refs_upd = pk_refs;
    if (op == FN_INC && pk_refs != REFS_MAX) begin
      refs_upd = pk_refs + 16'sd1;
    end else if (op == FN_DEC && pk_refs != REFS_MIN) begin
      refs_upd = pk_refs - 16'sd1;
    end
  end

  // write port steering
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = '0;
    mem_wdata = '0;
    case (state)
      S_INIT: begin
        mem_we    = 1'b1;
        mem_wdata = {{ID_BITS{1'b0}}, 32'd0, pool, 16'd0};
      end
      S_EVAL: begin
        if (op == FN_ALLOC && found && rest != 32'd0 && split_ok) begin
          mem_we    = 1'b1;
          mem_waddr = slot_idx;
          mem_wdata = {next_ident, pk_off + req_size, rest, 16'd0};
        end else if ((op == FN_INC || op == FN_DEC) && found) begin
          mem_we    = 1'b1;
          mem_waddr = pk_idx;
          mem_wdata = {pk_ident, pk_off, pk_len, refs_upd};
        end
      end
      S_WR2: begin
        mem_we    = 1'b1;
        mem_waddr = pk_idx;
        mem_wdata = {pk_ident, pk_off, req_size, 16'sd1};
      end
      S_MEVAL: begin
        if (cur_dirty && (!found || !merge_ok)) begin
          mem_we    = 1'b1;
          mem_waddr = cur_idx;
          mem_wdata = {cur_ident, cur_off, cur_len, cur_refs};
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_INIT;
      pool       <= POOL_RESET;
      valid_q    <= MAX_BLOCKS'(1);
      free_q     <= MAX_BLOCKS'(1);
      next_ident <= ID_BITS'(1);
      issuing    <= 1'b0;
      issue_cnt  <= '0;
      rv         <= 1'b0;
    end else begin
      rv   <= issuing;
      ridx <= issue_cnt;
      if (issuing) begin
        if (issue_cnt == LAST) begin
          issuing <= 1'b0;
        end else begin
          issue_cnt <= issue_cnt + AW'(1);
        end
      end

      case (state)
        S_INIT: begin
          if (cfg_fire) begin
            pool <= cfg_data;
          end else begin
            state <= S_IDLE;
          end
        end

        S_IDLE: begin
          if (cfg_fire) begin
            pool       <= cfg_data;
            valid_q    <= MAX_BLOCKS'(1);
            free_q     <= MAX_BLOCKS'(1);
            next_ident <= ID_BITS'(1);
            state      <= S_INIT;
          end else if (cmd_fire) begin
            op         <= cmd.func;
            req_size   <= cmd.request_size;
            req_tid    <= cmd.target_id;
            found      <= 1'b0;
            slot_found <= 1'b0;
            freed      <= '0;
            issuing    <= 1'b1;
            issue_cnt  <= '0;
            state      <= S_SCAN;
          end
        end

        S_SCAN: begin
          if (rv) begin
            case (op)
              FN_ALLOC: begin
                if (r_v && r_f && r_len >= req_size && (!found || r_ident < pk_ident)) begin
                  found    <= 1'b1;
                  pk_idx   <= ridx;
                  pk_ident <= r_ident;
                  pk_off   <= r_off;
                  pk_len   <= r_len;
                end
                if (!r_v && !slot_found) begin
                  slot_found <= 1'b1;
                  slot_idx   <= ridx;
                end
              end
              FN_INC, FN_DEC: begin
                if (r_v && !r_f && !found && EW'(r_ident) == EW'(req_tid)) begin
                  found    <= 1'b1;
                  pk_idx   <= ridx;
                  pk_ident <= r_ident;
                  pk_off   <= r_off;
                  pk_len   <= r_len;
                  pk_refs  <= r_refs;
                end
              end
              FN_COLLECT: begin
                if (r_v && !r_f && r_refs == 16'sd0) begin
                  free_q[ridx] <= 1'b1;
                  if (freed != FREED_MAX) begin
                    freed <= freed + 7'd1;
                  end
                end
              end
              default: ;
            endcase
            if (ridx == LAST) begin
              state <= S_EVAL;
            end
          end
        end

        S_EVAL: begin
          res_q.granted_id <= 16'd0;
          case (op)
            FN_ALLOC: begin
              res_q.freed_count <= 7'd0;
              if (!found) begin
                res_q.status <= ST_NOFIT;
                state        <= S_DONE;
              end else if (rest != 32'd0 && !split_ok) begin
                res_q.status <= ST_EXHAUST;
                state        <= S_DONE;
              end else begin
                res_q.status <= ST_OK;
                if (rest != 32'd0) begin
                  valid_q[slot_idx] <= 1'b1;
                  free_q[slot_idx]  <= 1'b1;
                  next_ident        <= next_ident + ID_BITS'(1);
                end
                state <= S_WR2;
              end
            end
            FN_INC, FN_DEC: begin
              res_q.freed_count <= 7'd0;
              res_q.status      <= found ? ST_OK : ST_BADID;
              state             <= S_DONE;
            end
            default: begin
              // collect: start the ordered merge walk
              res_q.status      <= ST_OK;
              res_q.freed_count <= freed;
              have_prev <= 1'b0;
              cur_valid <= 1'b0;
              cur_dirty <= 1'b0;
              found     <= 1'b0;
              issuing   <= 1'b1;
              issue_cnt <= '0;
              state     <= S_MSCAN;
            end
          endcase
        end

        S_WR2: begin
          free_q[pk_idx]   <= 1'b0;
          res_q.granted_id <= gext[15:0];
          state            <= S_DONE;
        end

        S_MSCAN: begin
          if (rv) begin
            if (r_v && (!have_prev || {r_off, r_ident} > {prev_off, prev_ident}) &&
                (!found || {r_off, r_ident} < {pk_off, pk_ident})) begin
              found    <= 1'b1;
              pk_idx   <= ridx;
              pk_ident <= r_ident;
              pk_off   <= r_off;
              pk_len   <= r_len;
              pk_refs  <= r_refs;
              pk_free  <= r_f;
            end
            if (ridx == LAST) begin
              state <= S_MEVAL;
            end
          end
        end

        S_MEVAL: begin
          if (!found) begin
            state <= S_DONE;
          end else begin
            if (merge_ok) begin
              cur_len        <= cur_len + pk_len;
              cur_dirty      <= 1'b1;
              valid_q[pk_idx] <= 1'b0;
              free_q[pk_idx]  <= 1'b0;
            end else begin
              cur_valid <= 1'b1;
              cur_dirty <= 1'b0;
              cur_free  <= pk_free;
              cur_idx   <= pk_idx;
              cur_ident <= pk_ident;
              cur_off   <= pk_off;
              cur_len   <= pk_len;
              cur_refs  <= pk_refs;
            end
            have_prev  <= 1'b1;
            prev_off   <= pk_off;
            prev_ident <= pk_ident;
            found      <= 1'b0;
            issuing    <= 1'b1;
            issue_cnt  <= '0;
            state      <= S_MSCAN;
          end
        end

        S_DONE: begin
          if (res_ready) begin
            state <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

  // free regions are always table members
  a_free_valid: assert property (@(posedge clk) disable iff (rst)
    (free_q & ~valid_q) == '0)
    else $error("free flag set on an invalid entry");

  // read data only arrives while a scan is running
  a_rv_scan: assert property (@(posedge clk) disable iff (rst)
    rv |-> (state == S_SCAN || state == S_MSCAN))
    else $error("read data outside a scan");

  // a split never lands on a live entry
  a_split_slot: assert property (@(posedge clk) disable iff (rst)
    (state == S_EVAL && op == FN_ALLOC && mem_we) |-> !valid_q[mem_waddr])
    else $error("split written over a valid entry");

  // an accepted word starts a scan
  a_cmd_scan: assert property (@(posedge clk) disable iff (rst)
    cmd_fire |=> (state == S_SCAN && issuing))
    else $error("accepted word did not start a scan");

endmodule
